FILE: sv/assert_macros.svh
// Assertion macros shared by the ranger RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");

// Check that an antecedent is followed by a consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/mser_pkg.sv
// Types, constants and helpers for the multi-sensor echo ranger
package mser_pkg;

	// Command codes of an input word
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_REQ  = 2'd1;
	localparam logic [1:0] CMD_TEMP = 2'd2;

	// Defaults
	localparam int          NUM_SENSORS_DEF = 4;
	localparam int          QUEUE_DEPTH_DEF = 4;
	localparam logic [15:0] SCAN_PERIOD_RST = 16'd59999;

	// Distance counter saturation
	localparam logic [15:0] DIST_MAX = 16'hFFFF;

	// Temperature conversion constants
	localparam logic [15:0] TEMP_OFFSET = 16'd673;
	localparam logic [8:0]  TEMP_GAIN   = 9'd423;
	localparam logic [5:0]  TEMP_BIAS   = 6'd10;

	// Transmit byte flag and request nibble mask
	localparam logic [7:0] TX_FLAG  = 8'h80;
	localparam logic [3:0] SEL_MASK = 4'h0F;

	// Beat codes of a request answer
	localparam logic [1:0] BEAT_LOW = 2'd0;
	localparam logic [1:0] BEAT_MID = 2'd1;
	localparam logic [1:0] BEAT_TOP = 2'd2;

	// One job handed from the front to the back
	typedef struct packed {
		logic        is_req;
		logic [5:0]  trig;
		logic        dist_valid;
		logic [2:0]  idx;
		logic [15:0] ticks;
		logic [7:0]  temp;
	} job_t;

	// Low byte of the temperature code: ((((adc-673)*423)>>10)-10)<<2
	function automatic logic [7:0] temp_code(input logic [9:0] adc);
		logic [15:0] diff;
		logic [24:0] prod;
		logic [5:0]  scaled;
		diff   = {6'd0, adc} - TEMP_OFFSET;
		prod   = 25'(diff) * 25'(TEMP_GAIN);
		scaled = prod[15:10] - TEMP_BIAS;
		return {scaled, 2'b00};
	endfunction

endpackage

FILE: sv/mser_front.sv
// Front end: accepts words, runs the scan timer and echo timing, builds jobs
module mser_front #(
	parameter int NUM_SENSORS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       cmd,
	input  logic [5:0]       echo_levels,
	input  logic [7:0]       request_byte,
	input  logic [9:0]       adc_sample,
	input  logic             push_ready,
	output logic             push,
	output mser_pkg::job_t   push_job
);
	import mser_pkg::*;

	localparam logic [2:0] NS3 = 3'(NUM_SENSORS);
	localparam logic [3:0] NS4 = 4'(NUM_SENSORS);

	logic [15:0] scan_period_q;
	logic [15:0] tick_count_q, tick_count_d;
	logic [2:0]  scan_index_q, scan_index_d;
	logic [2:0]  armed_sensor_q, armed_sensor_d;
	logic        armed_q, armed_d;
	logic        measuring_q, measuring_d;
	logic        prev_echo_q, prev_echo_d;
	logic [15:0] echo_elapsed_q, echo_elapsed_d;
	logic [15:0] dist_q [NUM_SENSORS];
	logic [7:0]  temp_q;

	logic        accept;
	logic        lvl;
	logic        new_lvl;
	logic        done;
	logic [15:0] done_dist;
	logic [5:0]  trig;
	logic [3:0]  sel;
	logic [15:0] rd_dist;
	logic        trig_fire;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	// Level of the armed line and of the line about to be armed
	assign lvl     = armed_q && (armed_sensor_q < NS3) && echo_levels[armed_sensor_q];
	assign new_lvl = (scan_index_q < NS3) && echo_levels[scan_index_q];

	// Tick processing: echo timing, then the scan timer
	always_comb begin
		tick_count_d   = tick_count_q;
		scan_index_d   = scan_index_q;
		armed_sensor_d = armed_sensor_q;
		armed_d        = armed_q;
		measuring_d    = measuring_q;
		echo_elapsed_d = echo_elapsed_q;
		done           = 1'b0;
		done_dist      = 16'd0;
		trig           = 6'd0;
		if (measuring_q) begin
			if (lvl) begin
				if (echo_elapsed_q != DIST_MAX)
					echo_elapsed_d = echo_elapsed_q + 16'd1;
			end else begin
				done_dist   = echo_elapsed_q;
				done        = 1'b1;
				measuring_d = 1'b0;
			end
		end else if (armed_q && lvl && !prev_echo_q) begin
			measuring_d    = 1'b1;
			echo_elapsed_d = 16'd1;
		end
		prev_echo_d = lvl;
		if (tick_count_q >= scan_period_q) begin
			if (!measuring_d) begin
				armed_sensor_d = scan_index_q;
				armed_d        = 1'b1;
				prev_echo_d    = new_lvl;
				trig           = 6'd1 << scan_index_q;
				scan_index_d   = (scan_index_q + 3'd1 >= NS3) ? 3'd0 : scan_index_q + 3'd1;
				tick_count_d   = 16'd0;
			end
		end else begin
			tick_count_d = tick_count_q + 16'd1;
		end
	end

	// Read the stored distance chosen by the request nibble
	assign sel = request_byte[3:0] & SEL_MASK;
	always_comb begin
		rd_dist = 16'd0;
		for (int k = 0; k < NUM_SENSORS; k++) begin
			if (sel < NS4 && sel == 4'(k))
				rd_dist = dist_q[k];
		end
	end

	// Build the job for the queue
	always_comb begin
		push_job = '0;
		push     = accept && (cmd == CMD_TICK || cmd == CMD_REQ);
		if (cmd == CMD_REQ) begin
			push_job.is_req = 1'b1;
			push_job.ticks  = rd_dist;
			push_job.temp   = temp_q;
		end else begin
			push_job.trig       = trig;
			push_job.dist_valid = done;
			push_job.idx        = done ? armed_sensor_q : armed_sensor_d;
			push_job.ticks      = done_dist;
		end
	end

	// Hold the scan period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= SCAN_PERIOD_RST;
		end else if (cfg_we) begin
			scan_period_q <= cfg_wdata;
		end
	end

	// Advance the scan and echo state on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= 16'd0;
			scan_index_q   <= 3'd0;
			armed_sensor_q <= 3'd0;
			armed_q        <= 1'b0;
			measuring_q    <= 1'b0;
			prev_echo_q    <= 1'b0;
			echo_elapsed_q <= 16'd0;
		end else if (accept && cmd == CMD_TICK) begin
			tick_count_q   <= tick_count_d;
			scan_index_q   <= scan_index_d;
			armed_sensor_q <= armed_sensor_d;
			armed_q        <= armed_d;
			measuring_q    <= measuring_d;
			prev_echo_q    <= prev_echo_d;
			echo_elapsed_q <= echo_elapsed_d;
		end
	end

	// Store a finished measurement for its sensor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SENSORS; k++)
				dist_q[k] <= 16'd0;
		end else if (accept && cmd == CMD_TICK && done) begin
			for (int k = 0; k < NUM_SENSORS; k++) begin
				if (armed_sensor_q == 3'(k))
					dist_q[k] <= done_dist;
			end
		end
	end

	// Convert and hold a temperature sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= 8'd0;
		end else if (accept && cmd == CMD_TEMP) begin
			temp_q <= temp_code(adc_sample);
		end
	end

	// A trigger fired on an accepted tick
	assign trig_fire = accept && cmd == CMD_TICK && trig != 6'd0;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_trig_onehot, clk, arst_n, $onehot0(trig))
	`ASSERT_NEXT(a_trig_arms, clk, arst_n, trig_fire, armed_q && tick_count_q == 16'd0)

endmodule

FILE: sv/mser_queue.sv
// Job queue between the front and back ends
module mser_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mser_pkg::job_t push_job,
	output logic           push_ready,
	input  logic           pop,
	output logic           head_valid,
	output mser_pkg::job_t head_job
);
	import mser_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != FULL);
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// Write the incoming job
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_job;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= FULL)

endmodule

FILE: sv/mser_back.sv
// Back end: turns queued jobs into output words
module mser_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  mser_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           kind,
	output logic [5:0]     trigger_mask,
	output logic           distance_valid,
	output logic [2:0]     sensor_index,
	output logic [15:0]    distance,
	output logic [7:0]     tx_byte,
	output logic           last
);
	import mser_pkg::*;

	logic        out_valid_q;
	logic        kind_q;
	logic [5:0]  trig_q;
	logic        dvalid_q;
	logic [2:0]  idx_q;
	logic [15:0] dist_q;
	logic [7:0]  tx_q;
	logic        last_q;
	logic [1:0]  beat_q;
	logic        load;
	logic [7:0]  tx_d;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && (!head_job.is_req || beat_q == BEAT_TOP);

	// Pick the byte of the current beat
	always_comb begin
		unique case (beat_q)
			BEAT_LOW: tx_d = {1'b0, head_job.ticks[6:0]};
			BEAT_MID: tx_d = {1'b0, head_job.ticks[13:7]};
			default:  tx_d = (TX_FLAG | {6'd0, head_job.ticks[15:14]}) + head_job.temp;
		endcase
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= head_job.is_req;
			if (head_job.is_req) begin
				trig_q   <= 6'd0;
				dvalid_q <= 1'b0;
				idx_q    <= 3'd0;
				dist_q   <= 16'd0;
				tx_q     <= tx_d;
				last_q   <= (beat_q == BEAT_TOP);
			end else begin
				trig_q   <= head_job.trig;
				dvalid_q <= head_job.dist_valid;
				idx_q    <= head_job.idx;
				dist_q   <= head_job.ticks;
				tx_q     <= 8'd0;
				last_q   <= 1'b1;
			end
		end
	end

	// Track output occupancy and the request beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= BEAT_LOW;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load && head_job.is_req) begin
				unique case (beat_q)
					BEAT_LOW: beat_q <= BEAT_MID;
					BEAT_MID: beat_q <= BEAT_TOP;
					default:  beat_q <= BEAT_LOW;
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign trigger_mask   = trig_q;
	assign distance_valid = dvalid_q;
	assign sensor_index   = idx_q;
	assign distance       = dist_q;
	assign tx_byte        = tx_q;
	assign last           = last_q;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_beat_on_req, clk, arst_n, beat_q == BEAT_LOW || (head_valid && head_job.is_req))
	`ASSERT_ALWAYS(a_tick_is_last, clk, arst_n, !out_valid_q || kind_q || last_q)

endmodule

FILE: sv/multi_sensor_echo_ranger_core.sv
// Top level of the multi-sensor echo ranger
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle while ready;
//   cmd selects a timer tick with echo levels, a request byte, or a temperature sample.
//   Output channel (out_valid/out_ready) gives one word per tick (kind 0) and
//   three words per request (kind 1: low 7 bits, middle 7 bits, then flag,
//   top 2 bits plus temperature), with last on the final word.
//   Temperature samples only update state; unused commands do nothing. No output.
//   cfg_we/cfg_wdata write the scan period; write only while the block idles.
// Path: a taken input word is written into the job queue, then loaded from the
//   queue head into the output register once that register is free.
// Throughput: one tick per cycle while out_ready is high; a request holds the
//   output register for its three beats before the next job can load.
// The job queue (QUEUE_DEPTH entries) lets the front end keep taking words
//   while the receiver stalls; in_ready drops only when the queue is full.
// Reset clears all timers, the stored distances and the temperature code, and
//   loads the scan period with 59999.
module multi_sensor_echo_ranger_core #(
	parameter int NUM_SENSORS = mser_pkg::NUM_SENSORS_DEF,
	parameter int QUEUE_DEPTH = mser_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [5:0]  echo_levels,
	input  logic [7:0]  request_byte,
	input  logic [9:0]  adc_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [5:0]  trigger_mask,
	output logic        distance_valid,
	output logic [2:0]  sensor_index,
	output logic [15:0] distance,
	output logic [7:0]  tx_byte,
	output logic        last
);
	import mser_pkg::*;

	job_t push_job, head_job;
	logic push, push_ready, pop, head_valid;

	mser_front #(.NUM_SENSORS(NUM_SENSORS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.echo_levels  (echo_levels),
		.request_byte (request_byte),
		.adc_sample   (adc_sample),
		.push_ready   (push_ready),
		.push         (push),
		.push_job     (push_job)
	);

	mser_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	mser_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_job       (head_job),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.trigger_mask   (trigger_mask),
		.distance_valid (distance_valid),
		.sensor_index   (sensor_index),
		.distance       (distance),
		.tx_byte        (tx_byte),
		.last           (last)
	);

endmodule
